/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/hrrn_pkg.sv */
package hrrn_pkg;

	localparam int MAX_JOBS_DEF = 16;

	localparam int ARR_W      = 16;
	localparam int BUR_W      = 16;
	localparam int IDX_OUT_W  = 4;
	localparam int TIME_OUT_W = 21;
	localparam int WAIT_W     = 20;
	localparam int IDLE_W     = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_MUL,
		ST_CMP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_init;
		logic mul;
		logic cmp;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic set_last;
	} status_t;

endpackage

/* rtl/core/hrrn_ctrl.sv */
module hrrn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_job,
	input  hrrn_pkg::status_t status,
	output hrrn_pkg::cmd_t    cmd,
	output logic              busy
);
	import hrrn_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_job) begin
						cmd.scan_init = 1'b1;
						state_d       = ST_PRIME;
					end
				end
			end
			ST_PRIME: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = status.scan_last ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.set_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_PRIME;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/hrrn_dp.sv */
module hrrn_dp #(
	parameter int MAX_JOBS = hrrn_pkg::MAX_JOBS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hrrn_pkg::cmd_t                  cmd,
	output hrrn_pkg::status_t               status,
	input  logic [hrrn_pkg::ARR_W-1:0]      arrival_time,
	input  logic [hrrn_pkg::BUR_W-1:0]      burst_time,
	output logic                            result_valid,
	output logic [hrrn_pkg::IDX_OUT_W-1:0]  job_index,
	output logic [hrrn_pkg::TIME_OUT_W-1:0] start_time,
	output logic [hrrn_pkg::TIME_OUT_W-1:0] finish_time,
	output logic [hrrn_pkg::TIME_OUT_W-1:0] turnaround,
	output logic [hrrn_pkg::WAIT_W-1:0]     wait_time,
	output logic [hrrn_pkg::IDLE_W-1:0]     idle_total,
	output logic                            last_result
);
	import hrrn_pkg::*;

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	// Time never exceeds the largest arrival plus every burst.
	localparam int TW = $clog2((MAX_JOBS + 1) * 65536);
	localparam int NW = TW + 1;
	localparam int PW = NW + BUR_W;

	logic [ARR_W-1:0] arr_mem [MAX_JOBS];
	logic [BUR_W-1:0] bur_mem [MAX_JOBS];
	logic [MAX_JOBS-1:0] done_q;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic [TW-1:0]     t_q;
	logic [IDLE_W-1:0] idle_q;
	logic [IW-1:0]     addr_q;

	logic [ARR_W-1:0] arr_s1;
	logic [BUR_W-1:0] bur_s1;
	logic [IW-1:0]    idx_s1;

	logic [PW-1:0]    lhs_s2;
	logic [PW-1:0]    rhs_s2;
	logic [ARR_W-1:0] arr_s2;
	logic [BUR_W-1:0] bur_s2;
	logic [IW-1:0]    idx_s2;
	logic             ready_s2;
	logic             pend_s2;

	logic             found_q;
	logic [IW-1:0]    best_idx_q;
	logic [ARR_W-1:0] best_arr_q;
	logic [BUR_W-1:0] best_bur_q;
	logic             any_q;
	logic [IW-1:0]    min_idx_q;
	logic [ARR_W-1:0] min_arr_q;
	logic [BUR_W-1:0] min_bur_q;

	logic                  valid_q;
	logic [IDX_OUT_W-1:0]  job_index_q;
	logic [TIME_OUT_W-1:0] start_time_q;
	logic [TIME_OUT_W-1:0] finish_time_q;
	logic [TIME_OUT_W-1:0] turnaround_q;
	logic [WAIT_W-1:0]     wait_time_q;
	logic [IDLE_W-1:0]     idle_total_q;
	logic                  last_result_q;

	logic [NW-1:0]     nc;
	logic [NW-1:0]     nb;
	logic              beats;
	logic [IW-1:0]     sel_idx;
	logic [ARR_W-1:0]  sel_arr;
	logic [BUR_W-1:0]  sel_bur;
	logic [TW-1:0]     start_t;
	logic [TW-1:0]     finish_t;
	logic [IDLE_W-1:0] idle_next;

	// Job store: one write port for loading, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q != CW'(MAX_JOBS))) begin
			arr_mem[count_q[IW-1:0]] <= arrival_time;
			bur_mem[count_q[IW-1:0]] <= burst_time;
		end
		arr_s1 <= arr_mem[addr_q];
		bur_s1 <= bur_mem[addr_q];
		idx_s1 <= addr_q;
	end

	// Normalized response numerators of the scanned entry and of the best so far.
	assign nc = NW'(t_q - TW'(arr_s1)) + NW'(bur_s1);
	assign nb = NW'(t_q - TW'(best_arr_q)) + NW'(best_bur_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			lhs_s2   <= PW'(nc * best_bur_q);
			rhs_s2   <= PW'(nb * bur_s1);
			arr_s2   <= arr_s1;
			bur_s2   <= bur_s1;
			idx_s2   <= idx_s1;
			ready_s2 <= !done_q[idx_s1] && (TW'(arr_s1) <= t_q);
			pend_s2  <= !done_q[idx_s1];
		end
	end

	assign beats = (lhs_s2 > rhs_s2) || ((lhs_s2 == rhs_s2) && (arr_s2 < best_arr_q));

	assign status.scan_last = ((CW'(idx_s2) + CW'(1)) == count_q);
	assign status.set_last  = ((k_q + CW'(1)) == count_q);

	// With no ready job, the earliest pending arrival at the lowest position runs next.
	assign sel_idx   = found_q ? best_idx_q : min_idx_q;
	assign sel_arr   = found_q ? best_arr_q : min_arr_q;
	assign sel_bur   = found_q ? best_bur_q : min_bur_q;
	assign start_t   = found_q ? t_q : TW'(min_arr_q);
	assign finish_t  = start_t + TW'(sel_bur);
	assign idle_next = found_q ? idle_q : (idle_q + IDLE_W'(TW'(min_arr_q) - t_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			t_q     <= '0;
			idle_q  <= '0;
			done_q  <= '0;
			addr_q  <= '0;
			found_q <= 1'b0;
			any_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.load && (count_q != CW'(MAX_JOBS))) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_init) begin
				addr_q  <= '0;
				found_q <= 1'b0;
				any_q   <= 1'b0;
			end
			if (cmd.mul) begin
				addr_q <= addr_q + IW'(1);
			end
			if (cmd.cmp) begin
				if (ready_s2 && (!found_q || beats)) begin
					found_q <= 1'b1;
				end
				if (pend_s2 && (!any_q || (arr_s2 < min_arr_q))) begin
					any_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				if (status.set_last) begin
					count_q <= '0;
					k_q     <= '0;
					t_q     <= '0;
					idle_q  <= '0;
					done_q  <= '0;
				end else begin
					k_q              <= k_q + CW'(1);
					t_q              <= finish_t;
					idle_q           <= idle_next;
					done_q[sel_idx]  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			if (ready_s2 && (!found_q || beats)) begin
				best_idx_q <= idx_s2;
				best_arr_q <= arr_s2;
				best_bur_q <= bur_s2;
			end
			if (pend_s2 && (!any_q || (arr_s2 < min_arr_q))) begin
				min_idx_q <= idx_s2;
				min_arr_q <= arr_s2;
				min_bur_q <= bur_s2;
			end
		end
		if (cmd.emit) begin
			job_index_q   <= IDX_OUT_W'(sel_idx);
			start_time_q  <= TIME_OUT_W'(start_t);
			finish_time_q <= TIME_OUT_W'(finish_t);
			turnaround_q  <= TIME_OUT_W'(finish_t - TW'(sel_arr));
			wait_time_q   <= WAIT_W'(start_t - TW'(sel_arr));
			idle_total_q  <= status.set_last ? idle_next : '0;
			last_result_q <= status.set_last;
		end
	end

	assign result_valid = valid_q;
	assign job_index    = job_index_q;
	assign start_time   = start_time_q;
	assign finish_time  = finish_time_q;
	assign turnaround   = turnaround_q;
	assign wait_time    = wait_time_q;
	assign idle_total   = idle_total_q;
	assign last_result  = last_result_q;

endmodule

/* rtl/core/hrrn_scheduler.sv */
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+-----------------------------------------
// job in    | start, busy (taken: start&!busy)| arrival_time, burst_time, last_job
// result    | result_valid (one-cycle strobe) | job_index, start_time, finish_time,
//           |                                 | turnaround, wait_time, idle_total,
//           |                                 | last_result
//
// Loading runs at one item per clock while the block is idle; busy holds off new
// items during a pass. Each scheduling decision runs a read-latency step, then a
// multiply step and a compare step per stored job, then the emit step; the job
// store's single read port and the cross-product multipliers make the scan visit
// the stored jobs one at a time.
// Reset clears the job count, time, idle total and done flags; the job store is
// not cleared and only loaded entries are read.
// The receiver cannot stall, so each result strobe lasts exactly one cycle.
`include "assert_macros.svh"

module hrrn_scheduler #(
	parameter int MAX_JOBS = hrrn_pkg::MAX_JOBS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hrrn_pkg::ARR_W-1:0]      arrival_time,
	input  logic [hrrn_pkg::BUR_W-1:0]      burst_time,
	input  logic                            last_job,
	output logic                            result_valid,
	output logic [hrrn_pkg::IDX_OUT_W-1:0]  job_index,
	output logic [hrrn_pkg::TIME_OUT_W-1:0] start_time,
	output logic [hrrn_pkg::TIME_OUT_W-1:0] finish_time,
	output logic [hrrn_pkg::TIME_OUT_W-1:0] turnaround,
	output logic [hrrn_pkg::WAIT_W-1:0]     wait_time,
	output logic [hrrn_pkg::IDLE_W-1:0]     idle_total,
	output logic                            last_result
);
	import hrrn_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The controller sequences loading, the per-job scan and the emit step.
	hrrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_job (last_job),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the job store, the ratio comparison and the result registers.
	hrrn_dp #(
		.MAX_JOBS (MAX_JOBS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.arrival_time (arrival_time),
		.burst_time   (burst_time),
		.result_valid (result_valid),
		.job_index    (job_index),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.turnaround   (turnaround),
		.wait_time    (wait_time),
		.idle_total   (idle_total),
		.last_result  (last_result)
	);

	// A closing job always starts a scheduling pass.
	`ASSERT_NEXT(a_last_starts_pass, clk, arst_n, start && !busy && last_job, busy)
	// Results other than the final one appear while the pass is still running.
	`ASSERT_IMPLY(a_mid_result_busy, clk, arst_n, result_valid && !last_result, busy)
	// The final result returns the block to idle.
	`ASSERT_IMPLY(a_final_result_idle, clk, arst_n, result_valid && last_result, !busy)
	// Decisions are separated by a full scan, so strobes never come back to back.
	`ASSERT_NEXT(a_strobe_single, clk, arst_n, result_valid, !result_valid)

endmodule

/* dv/hrrn_result_checker.sv */
`timescale 1ns / 1ps

// Watches the job and result channels and keeps its own schedule of expected results.
module hrrn_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [hrrn_pkg::ARR_W-1:0]      arrival_time,
	input  logic [hrrn_pkg::BUR_W-1:0]      burst_time,
	input  logic                            last_job,
	input  logic                            result_valid,
	input  logic [hrrn_pkg::IDX_OUT_W-1:0]  job_index,
	input  logic [hrrn_pkg::TIME_OUT_W-1:0] start_time,
	input  logic [hrrn_pkg::TIME_OUT_W-1:0] finish_time,
	input  logic [hrrn_pkg::TIME_OUT_W-1:0] turnaround,
	input  logic [hrrn_pkg::WAIT_W-1:0]     wait_time,
	input  logic [hrrn_pkg::IDLE_W-1:0]     idle_total,
	input  logic                            last_result,
	output int                              mismatches,
	output int                              outstanding
);
	import hrrn_pkg::*;

	localparam int SLOTS = MAX_JOBS_DEF;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]  job;
		logic [TIME_OUT_W-1:0] t_start;
		logic [TIME_OUT_W-1:0] t_finish;
		logic [TIME_OUT_W-1:0] t_turn;
		logic [WAIT_W-1:0]     t_wait;
		logic [IDLE_W-1:0]     idle;
		logic                  last;
	} sched_rec_t;

	logic [ARR_W-1:0] arr_mem [SLOTS];
	logic [BUR_W-1:0] bur_mem [SLOTS];
	bit               ran [SLOTS];
	int               loaded = 0;
	int               bad_count = 0;
	int               seen_count = 0;
	sched_rec_t       run_order_q [$];
	sched_rec_t       seen;
	sched_rec_t       want;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// True when job c has a strictly higher response ratio than job b, or an equal one
	// and an earlier arrival. Cross-products keep the comparison exact.
	function automatic bit outranks(int c, int b, logic [31:0] now);
		longint unsigned nc, nb, lhs, rhs;
		nc = 64'(now - 32'(arr_mem[c])) + 64'(bur_mem[c]);
		nb = 64'(now - 32'(arr_mem[b])) + 64'(bur_mem[b]);
		lhs = nc * 64'(bur_mem[b]);
		rhs = nb * 64'(bur_mem[c]);
		if (lhs != rhs)
			return lhs > rhs;
		return arr_mem[c] < arr_mem[b];
	endfunction

	function automatic int best_ready(logic [31:0] now);
		int pick = -1;
		for (int i = 0; i < loaded; i++)
			if (!ran[i] && 32'(arr_mem[i]) <= now)
				if (pick < 0 || outranks(i, pick, now))
					pick = i;
		return pick;
	endfunction

	task automatic schedule_set();
		logic [31:0] now, fin, idle, next;
		int pick;
		sched_rec_t r;
		now = 0;
		idle = 0;
		for (int k = 0; k < loaded; k++) begin
			pick = best_ready(now);
			if (pick < 0) begin
				next = '1;
				for (int i = 0; i < loaded; i++)
					if (!ran[i] && 32'(arr_mem[i]) < next)
						next = 32'(arr_mem[i]);
				idle = (idle + next - now) & 32'h0000_FFFF;
				now = next;
				pick = best_ready(now);
			end
			fin = now + 32'(bur_mem[pick]);
			ran[pick] = 1'b1;
			r.job = pick[IDX_OUT_W-1:0];
			r.t_start = now[TIME_OUT_W-1:0];
			r.t_finish = fin[TIME_OUT_W-1:0];
			r.t_turn = TIME_OUT_W'(fin - 32'(arr_mem[pick]));
			r.t_wait = WAIT_W'(now - 32'(arr_mem[pick]));
			r.last = (k == loaded - 1);
			r.idle = r.last ? idle[IDLE_W-1:0] : '0;
			run_order_q.push_back(r);
			now = fin;
		end
		loaded = 0;
		ran = '{default: 1'b0};
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				seen = '{job_index, start_time, finish_time, turnaround, wait_time,
					idle_total, last_result};
				if (run_order_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("result %0d arrived with nothing expected: job=%0d start=%0d",
							seen_count, seen.job, seen.t_start);
				end else begin
					want = run_order_q.pop_front();
					if (seen.job !== want.job || seen.t_start !== want.t_start ||
						seen.t_finish !== want.t_finish || seen.t_turn !== want.t_turn ||
						seen.t_wait !== want.t_wait || seen.idle !== want.idle ||
						seen.last !== want.last) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("result %0d exp job=%0d st=%0d fin=%0d tat=%0d wt=%0d",
								seen_count, want.job, want.t_start, want.t_finish,
								want.t_turn, want.t_wait, " idle=%0d last=%0d",
								want.idle, want.last);
							$display("result %0d got job=%0d st=%0d fin=%0d tat=%0d wt=%0d",
								seen_count, seen.job, seen.t_start, seen.t_finish,
								seen.t_turn, seen.t_wait, " idle=%0d last=%0d",
								seen.idle, seen.last);
						end
					end
				end
				seen_count++;
			end
			if (start && !busy) begin
				if (loaded < SLOTS) begin
					arr_mem[loaded] = arrival_time;
					bur_mem[loaded] = burst_time;
					ran[loaded] = 1'b0;
					loaded++;
				end
				if (last_job)
					schedule_set();
			end
		end
		mismatches <= bad_count;
		outstanding <= run_order_q.size();
	end

endmodule

/* dv/hrrn_scheduler_tb.sv */
`timescale 1ns / 1ps

// Top of the scheduler bench. It only makes stimulus and gives the verdict; the checker
// beside the block predicts every result and counts mismatches.
module hrrn_scheduler_tb;
	import hrrn_pkg::*;

	localparam int SLOTS = MAX_JOBS_DEF;

	// Every input is known from time zero.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [ARR_W-1:0]      arrival_time = '0;
	logic [BUR_W-1:0]      burst_time = '0;
	logic                  last_job = 1'b0;
	logic                  busy;
	logic                  result_valid;
	logic [IDX_OUT_W-1:0]  job_index;
	logic [TIME_OUT_W-1:0] start_time;
	logic [TIME_OUT_W-1:0] finish_time;
	logic [TIME_OUT_W-1:0] turnaround;
	logic [WAIT_W-1:0]     wait_time;
	logic [IDLE_W-1:0]     idle_total;
	logic                  last_result;
	int                    errors;
	int                    pending;
	int                    jobs_stored = 0;
	int                    sets_done = 0;

	hrrn_scheduler dut (
		.clk, .arst_n, .start, .busy, .arrival_time, .burst_time, .last_job,
		.result_valid, .job_index, .start_time, .finish_time, .turnaround,
		.wait_time, .idle_total, .last_result
	);

	hrrn_result_checker u_check (
		.clk, .arst_n, .start, .busy, .arrival_time, .burst_time, .last_job,
		.result_valid, .job_index, .start_time, .finish_time, .turnaround,
		.wait_time, .idle_total, .last_result,
		.mismatches(errors), .outstanding(pending)
	);

	always #10 clk = ~clk;

	// Most gaps are zero or short; a few are long enough to span several scan steps.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one job item and holds it until the block takes it. A gap of zero leaves
	// start high, so the caller must offer the next item in the same time step.
	task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
		input logic closes, input int gap);
		start <= 1'b1;
		arrival_time <= arr;
		burst_time <= bur;
		last_job <= closes;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One random job set. Arrivals are either spread over the whole range (long idle
	// jumps), packed near zero, or clumped on a few values so that ratios and arrivals
	// tie often. Bursts are full range, tiny, or from a small pool of even values.
	// Now and then a set runs past the store size, so the extra items are dropped.
	task automatic random_set(input bit drain);
		int n, amode, bmode, base, g;
		bit calm;
		logic [ARR_W-1:0] a;
		logic [BUR_W-1:0] b;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS, SLOTS + 2)
			: $urandom_range(1, SLOTS);
		amode = $urandom_range(0, 2);
		bmode = $urandom_range(0, 2);
		base = $urandom_range(0, 65535 - 40);
		calm = ($urandom_range(0, 3) == 0);
		for (int j = 0; j < n; j++) begin
			case (amode)
				0: a = ARR_W'($urandom_range(0, 65535));
				1: a = ARR_W'($urandom_range(0, 30));
				default: a = ARR_W'(base + 4 * $urandom_range(0, 8));
			endcase
			case (bmode)
				0: b = BUR_W'($urandom_range(1, 65535));
				1: b = BUR_W'($urandom_range(1, 8));
				default: b = BUR_W'(2 * $urandom_range(1, 3));
			endcase
			g = calm ? 0 : pick_gap();
			// Start must drop after the closing item when the sender is about to sit out.
			if (j == n - 1 && drain && g == 0)
				g = 1;
			send_job(a, b, j == n - 1, g);
		end
		jobs_stored += (n < SLOTS) ? n : SLOTS;
		if (drain)
			while (pending != 0) @(posedge clk);
	endtask

	// Generous ceiling on the whole run.
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single job at time zero with the shortest burst.
		send_job(16'd0, 16'd1, 1'b1, pick_gap());
		// Single job at the latest arrival with the longest burst: one long idle jump.
		send_job(16'hFFFF, 16'hFFFF, 1'b1, pick_gap());
		// Tie breaks. The first two are identical, so load order decides. At time 4 the
		// second job and the third have equal ratios, so the earlier arrival wins. The
		// last two are identical again.
		send_job(16'd0, 16'd4, 1'b0, pick_gap());
		send_job(16'd0, 16'd4, 1'b0, pick_gap());
		send_job(16'd2, 16'd2, 1'b0, pick_gap());
		send_job(16'd2, 16'd2, 1'b1, pick_gap());
		// A zero burst finishes at its own start; the cross-product rule is used as is.
		send_job(16'd5, 16'd0, 1'b0, pick_gap());
		send_job(16'd5, 16'd3, 1'b1, pick_gap());
		// A full store plus one: the extra item is dropped but its last flag still closes
		// the set. Long bursts push the times toward the top of their fields.
		for (int i = 0; i <= SLOTS; i++)
			send_job(16'(i * 3), (i % 2) ? 16'hFFFF : 16'(i + 1), i == SLOTS,
				(i == SLOTS) ? 1 : pick_gap());
		// The directed sets above count toward the total number of stored jobs.
		jobs_stored += 8 + SLOTS;

		// Random sets. The first one, and some later ones, let every result drain
		// before the next item is offered.
		while (jobs_stored < 100) begin
			random_set(sets_done == 0 || $urandom_range(0, 4) == 0 || jobs_stored >= 84);
			sets_done++;
		end

		// The last set always drains; give the block a few scan steps more so that any
		// stray strobe is seen before the verdict.
		while (pending != 0) @(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hrrn_pkg.sv
rtl/core/hrrn_ctrl.sv
rtl/core/hrrn_dp.sv
rtl/core/hrrn_scheduler.sv
dv/hrrn_result_checker.sv
dv/hrrn_scheduler_tb.sv
